### rtl/brb_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the byte ring buffer core.
// No dependencies; imported by byte_ring_buffer_core.
package brb_pkg;

  localparam int SIZE_W    = 11;
  localparam int BYTE_W    = 8;
  localparam int PCT_W     = 7;
  localparam int PCT_SCALE = 100;

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_READ  = 2'd1,
    ACT_PEEK  = 2'd2,
    ACT_CLEAR = 2'd3
  } action_t;

  typedef enum logic [4:0] {
    ST_IDLE  = 5'b00001,
    ST_LOAD  = 5'b00010,
    ST_DIV   = 5'b00100,
    ST_READ  = 5'b01000,
    ST_DRAIN = 5'b10000
  } state_t;

endpackage

### rtl/byte_ring_buffer_core.sv
`timescale 1ns / 1ps
// Byte FIFO ring with block writes, read/peek runs and a fill percentage.
// Depends on brb_pkg; holds the byte store memory and the percent divider.
//
//  channel   handshake                 payload
//  -------   -----------------------   ---------------------------------------------
//  command   start / busy              action, req_length, data_byte, block_start
//  config    size_wr_en                size_wr_data
//  result    strobe (one cycle)        out_byte, moved_count, last, write_accepted,
//                                      fill_level, fill_percent
//
// A write, clear or empty read or peek emits one result word after ST_LOAD and the divider steps.
// A read or peek of n bytes runs ST_LOAD, ST_DIV, ST_READ and ST_DRAIN and emits n consecutive
// result words. The seven-step restoring divider computes fill_percent, and the single read
// port of the byte store delivers one byte per cycle.
// Reset is synchronous and empties the ring with size 0; the store needs no clearing pass.
// The receiver cannot stall; busy holds off new commands until the last word is out.
module byte_ring_buffer_core #(
  parameter int DEPTH    = 1024,
  parameter int MAX_READ = 64
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      action,
  input  logic [brb_pkg::SIZE_W-1:0]      req_length,
  input  logic [brb_pkg::BYTE_W-1:0]      data_byte,
  input  logic                            block_start,
  input  logic                            size_wr_en,
  input  logic [brb_pkg::SIZE_W-1:0]      size_wr_data,
  output logic                            strobe,
  output logic [brb_pkg::BYTE_W-1:0]      out_byte,
  output logic [brb_pkg::SIZE_W-1:0]      moved_count,
  output logic                            last,
  output logic                            write_accepted,
  output logic [brb_pkg::SIZE_W-1:0]      fill_level,
  output logic [brb_pkg::PCT_W-1:0]       fill_percent
);
  import brb_pkg::*;

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = ((AW > SIZE_W) ? AW : SIZE_W) + 1;
  localparam int NW = $clog2(MAX_READ + 1);
  localparam int RW = SIZE_W + PCT_W;
  localparam int SW = $clog2(PCT_W);
  localparam logic [CW-1:0]     DEPTH_C    = CW'(DEPTH);
  localparam logic [SIZE_W-1:0] MAX_READ_C = SIZE_W'(MAX_READ);

  logic [BYTE_W-1:0] byte_store [DEPTH];

  state_t              state, state_next;
  logic [SIZE_W-1:0]   cache_size;
  logic [AW-1:0]       read_pos, read_pos_next;
  logic [AW-1:0]       write_pos, write_pos_next;
  logic [SIZE_W-1:0]   fill_count, fill_count_next;
  logic [SIZE_W-1:0]   block_remaining, block_remaining_next;
  logic                block_ok, block_ok_next;
  logic [SIZE_W-1:0]   moved, moved_next;
  logic [NW-1:0]       run_len, run_len_next;
  logic                single, single_next;
  logic [NW-1:0]       issue_cnt;
  logic [AW-1:0]       rd_addr;
  logic [BYTE_W-1:0]   rd_data;
  logic                rd_pend;
  logic                rd_last;
  logic [RW-1:0]       rem, rem_next;
  logic [RW-1:0]       dsr;
  logic [PCT_W-1:0]    quo, quo_next;
  logic [SW-1:0]       step;
  logic                accept;
  logic                mem_we;
  logic                div_ge;
  logic                issue_last;
  logic                emit_single;
  action_t             act;
  logic [SIZE_W-1:0]   free_space;
  logic [SIZE_W-1:0]   n_req;
  logic [SIZE_W-1:0]   n_full;
  logic [CW-1:0]       rd_sum;
  logic [CW-1:0]       rd_wrap;
  logic                blk_ok;
  logic [SIZE_W-1:0]   eff_size;

  function automatic logic [AW-1:0] next_pos(input logic [AW-1:0] p,
                                             input logic [SIZE_W-1:0] size);
    logic [CW-1:0] inc;
    inc = CW'(p) + CW'(1);
    return (inc >= CW'(size)) ? '0 : inc[AW-1:0];
  endfunction

  assign accept = start && !busy;
  assign busy   = (state != ST_IDLE);
  assign act    = action_t'(action);

  assign eff_size = (CW'(size_wr_data) > DEPTH_C) ? DEPTH_C[SIZE_W-1:0] : size_wr_data;

  assign free_space = cache_size - fill_count;
  assign n_req      = (req_length > MAX_READ_C) ? MAX_READ_C : req_length;
  assign n_full     = (n_req > fill_count) ? fill_count : n_req;
  assign rd_sum     = CW'(read_pos) + CW'(n_full);
  assign rd_wrap    = (rd_sum >= CW'(cache_size)) ? rd_sum - CW'(cache_size) : rd_sum;
  assign blk_ok     = (req_length != '0) && (req_length <= free_space);

  always_comb begin
    read_pos_next        = read_pos;
    write_pos_next       = write_pos;
    fill_count_next      = fill_count;
    block_remaining_next = block_remaining;
    block_ok_next        = block_ok;
    moved_next           = moved;
    run_len_next         = run_len;
    single_next          = single;
    mem_we               = 1'b0;
    if (accept) begin
      unique case (act)
        ACT_WRITE: begin
          moved_next  = '0;
          single_next = 1'b1;
          if (block_start) begin
            block_ok_next        = blk_ok;
            block_remaining_next = blk_ok ? req_length : '0;
            moved_next           = blk_ok ? req_length : '0;
          end
          if (block_remaining_next != '0 && fill_count < cache_size &&
              CW'(write_pos) < CW'(cache_size)) begin
            mem_we               = 1'b1;
            write_pos_next       = next_pos(write_pos, cache_size);
            fill_count_next      = fill_count + SIZE_W'(1);
            block_remaining_next = block_remaining_next - SIZE_W'(1);
            if (!block_start) begin
              moved_next = SIZE_W'(1);
            end
          end
        end
        ACT_READ, ACT_PEEK: begin
          moved_next   = n_full;
          run_len_next = NW'(n_full);
          single_next  = (n_full == '0);
          if (act == ACT_READ && n_full != '0) begin
            read_pos_next   = rd_wrap[AW-1:0];
            fill_count_next = fill_count - n_full;
          end
        end
        ACT_CLEAR: begin
          read_pos_next        = '0;
          write_pos_next       = '0;
          fill_count_next      = '0;
          block_remaining_next = '0;
          block_ok_next        = 1'b0;
          moved_next           = '0;
          single_next          = 1'b1;
        end
      endcase
    end
  end

  assign div_ge      = (cache_size != '0) && (dsr <= rem);
  assign rem_next    = div_ge ? rem - dsr : rem;
  assign issue_last  = (issue_cnt == run_len - NW'(1));
  assign emit_single = (state == ST_DIV) && (step == '0) && single;

  always_comb begin
    quo_next       = quo;
    quo_next[step] = div_ge;
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:  if (accept) state_next = ST_LOAD;
      ST_LOAD:  state_next = ST_DIV;
      ST_DIV:   if (step == '0) state_next = single ? ST_IDLE : ST_READ;
      ST_READ:  if (issue_last) state_next = ST_DRAIN;
      ST_DRAIN: state_next = ST_IDLE;
      default:  state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      cache_size      <= '0;
      read_pos        <= '0;
      write_pos       <= '0;
      fill_count      <= '0;
      block_remaining <= '0;
      block_ok        <= 1'b0;
      strobe          <= 1'b0;
      rd_pend         <= 1'b0;
    end else begin
      state   <= state_next;
      strobe  <= emit_single || rd_pend;
      rd_pend <= (state == ST_READ);
      if (size_wr_en) begin
        cache_size      <= eff_size;
        read_pos        <= '0;
        write_pos       <= '0;
        fill_count      <= '0;
        block_remaining <= '0;
        block_ok        <= 1'b0;
      end else begin
        read_pos        <= read_pos_next;
        write_pos       <= write_pos_next;
        fill_count      <= fill_count_next;
        block_remaining <= block_remaining_next;
        block_ok        <= block_ok_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    moved   <= moved_next;
    run_len <= run_len_next;
    single  <= single_next;
    if (accept) begin
      rd_addr   <= read_pos;
      issue_cnt <= '0;
    end
    unique case (state)
      ST_LOAD: begin
        rem  <= RW'(fill_count) * RW'(PCT_SCALE);
        dsr  <= RW'(cache_size) << (PCT_W - 1);
        quo  <= '0;
        step <= SW'(PCT_W - 1);
      end
      ST_DIV: begin
        rem  <= rem_next;
        dsr  <= dsr >> 1;
        quo  <= quo_next;
        step <= step - SW'(1);
      end
      ST_READ: begin
        rd_last   <= issue_last;
        rd_addr   <= next_pos(rd_addr, cache_size);
        issue_cnt <= issue_cnt + NW'(1);
      end
      ST_IDLE, ST_DRAIN: begin
      end
      default: begin
      end
    endcase
    if (emit_single) begin
      out_byte       <= '0;
      moved_count    <= moved;
      last           <= 1'b1;
      write_accepted <= block_ok;
      fill_level     <= fill_count;
      fill_percent   <= quo_next;
    end else if (rd_pend) begin
      out_byte       <= rd_data;
      moved_count    <= moved;
      last           <= rd_last;
      write_accepted <= block_ok;
      fill_level     <= fill_count;
      fill_percent   <= quo;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      byte_store[write_pos] <= data_byte;
    end
    if (state == ST_READ) begin
      rd_data <= byte_store[rd_addr];
    end
  end

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    accept |=> busy)
    else $error("Accepted command did not raise busy.");

  a_run_contiguous: assert property (@(posedge clk) disable iff (rst)
    strobe && !last |=> strobe)
    else $error("Result run was broken before its last word.");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill_count <= cache_size)
    else $error("Fill count exceeds the ring size.");

  a_pos_bound: assert property (@(posedge clk) disable iff (rst)
    cache_size != '0 |-> (CW'(read_pos) < CW'(cache_size)) &&
                         (CW'(write_pos) < CW'(cache_size)))
    else $error("Ring pointer outside the ring size.");

endmodule
